FILE: rtl/gtm_pkg.sv
// Shared types, constants and saturation helper for the 4x4 GEMM tile MAC.
`timescale 1ns / 1ps
`default_nettype none

package gtm_pkg;

	// Tile geometry and fixed field widths
	localparam int unsigned TILE      = 4;
	localparam int unsigned ROW_W     = 2;
	localparam int unsigned A_FIELD_W = 16;
	localparam int unsigned V_FIELD_W = 40;
	localparam int unsigned OUT_W     = 40;

	// Defaults for the top-level parameters
	localparam int unsigned OPERAND_WIDTH_DEF = 16;
	localparam int unsigned ACC_WIDTH_DEF     = 40;

	// Item function codes
	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_MAC  = 1'b1
	} gtm_func_t;

	// Input transaction
	typedef struct packed {
		gtm_func_t                     func;
		logic [ROW_W-1:0]              row;
		logic signed [A_FIELD_W-1:0]   a0;
		logic signed [A_FIELD_W-1:0]   a1;
		logic signed [A_FIELD_W-1:0]   a2;
		logic signed [A_FIELD_W-1:0]   a3;
		logic signed [V_FIELD_W-1:0]   v0;
		logic signed [V_FIELD_W-1:0]   v1;
		logic signed [V_FIELD_W-1:0]   v2;
		logic signed [V_FIELD_W-1:0]   v3;
		logic                          last;
	} gtm_in_t;

	// Result transaction: one tile row
	typedef struct packed {
		logic [ROW_W-1:0]              out_row;
		logic signed [OUT_W-1:0]       c0;
		logic signed [OUT_W-1:0]       c1;
		logic signed [OUT_W-1:0]       c2;
		logic signed [OUT_W-1:0]       c3;
		logic                          tile_done;
	} gtm_out_t;

	// Per-cell control from the pipeline
	typedef struct packed {
		logic cap;  // capture a new product
		logic ld;   // load the accumulator with a prior output
		logic mac;  // add the registered product
		logic clr;  // clear instead of keeping the sum (tile end)
	} gtm_ctl_t;

	// Clamp a signed value to the signed range of w bits (w <= 64)
	function automatic logic signed [63:0] gtm_sat(input logic signed [63:0] x,
			input int unsigned w);
		logic [63:0]        hi_u;
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi_u = (64'd1 << (w - 1)) - 64'd1;
		hi   = $signed(hi_u);
		lo   = ~hi;
		if (x > hi) begin
			return hi;
		end else if (x < lo) begin
			return lo;
		end
		return x;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/gemm_tile_4x4_mac.sv
// Top level of the 4x4 GEMM output-tile engine with valid/stall channels.
// A last step's rows pass stages 1 and 2 into the output buffer, leaving one per cycle unless stalled.
// Throughput: one item per cycle while op_stall is low.
// A last step stalls only if the previous tile's four-row output buffer has not drained.
// Reset (arst_n low, asynchronous) zeroes all 16 accumulators and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module gemm_tile_4x4_mac
	import gtm_pkg::*;
#(
	parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF,
	parameter int unsigned ACC_WIDTH     = ACC_WIDTH_DEF
) (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       op_valid,
	output logic      op_stall,
	input  wire gtm_in_t op,
	output logic      res_valid,
	input  wire       res_stall,
	output gtm_out_t  res
);

	// Stage 1: input register
	logic    valid_s1;
	gtm_in_t item_s1;

	// Stage 2: products live in the cells; control and load values here
	logic                        valid_s2;
	gtm_func_t                   func_s2;
	logic [ROW_W-1:0]            row_s2;
	logic                        last_s2;
	logic signed [ACC_WIDTH-1:0] ld_s2 [TILE];

	// Output buffer
	logic signed [ACC_WIDTH-1:0] rows_q [TILE][TILE];
	logic                        busy_q;
	logic [ROW_W-1:0]            cnt_q;

	logic signed [A_FIELD_W-1:0]     a_fld  [TILE];
	logic signed [V_FIELD_W-1:0]     v_fld  [TILE];
	logic signed [OPERAND_WIDTH-1:0] a_op   [TILE];
	logic signed [OPERAND_WIDTH-1:0] b_op   [TILE];
	logic signed [ACC_WIDTH-1:0]     ld_val [TILE];
	logic signed [ACC_WIDTH-1:0]     acc_nxt[TILE][TILE];

	logic buf_free;
	logic take;
	logic tile_end;
	logic s2_go;
	logic s1_go;
	logic fire;

	assign a_fld[0] = item_s1.a0;
	assign a_fld[1] = item_s1.a1;
	assign a_fld[2] = item_s1.a2;
	assign a_fld[3] = item_s1.a3;
	assign v_fld[0] = item_s1.v0;
	assign v_fld[1] = item_s1.v1;
	assign v_fld[2] = item_s1.v2;
	assign v_fld[3] = item_s1.v3;

	// Handshake and pipeline advance
	assign take     = busy_q && !res_stall;
	assign buf_free = !busy_q || (take && (cnt_q == ROW_W'(TILE - 1)));
	assign tile_end = valid_s2 && (func_s2 == FUNC_MAC) && last_s2;
	assign s2_go    = !tile_end || buf_free;
	assign s1_go    = !valid_s1 || s2_go;
	assign op_stall = !s1_go;
	assign fire     = valid_s2 && s2_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_go) begin
				valid_s1 <= op_valid;
			end
			if (s2_go) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			item_s1 <= op;
		end
		if (s2_go) begin
			func_s2 <= item_s1.func;
			row_s2  <= item_s1.row;
			last_s2 <= item_s1.last;
			ld_s2   <= ld_val;
		end
	end

	// Operand clamping and the 4x4 cell array
	for (genvar r = 0; r < TILE; r++) begin : g_row
		gtm_ctl_t ctl;

		assign a_op[r]   = OPERAND_WIDTH'(gtm_sat(64'(a_fld[r]), OPERAND_WIDTH));
		assign b_op[r]   = OPERAND_WIDTH'(gtm_sat(64'(v_fld[r]), OPERAND_WIDTH));
		assign ld_val[r] = ACC_WIDTH'(gtm_sat(64'(v_fld[r]), ACC_WIDTH));

		assign ctl.cap = s2_go;
		assign ctl.ld  = fire && (func_s2 == FUNC_LOAD) && (row_s2 == ROW_W'(r));
		assign ctl.mac = fire && (func_s2 == FUNC_MAC);
		assign ctl.clr = last_s2;

		for (genvar c = 0; c < TILE; c++) begin : g_col
			gtm_cell #(
				.OPERAND_WIDTH(OPERAND_WIDTH),
				.ACC_WIDTH    (ACC_WIDTH)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.a_op   (a_op[r]),
				.b_op   (b_op[c]),
				.ld_val (ld_s2[c]),
				.acc_nxt(acc_nxt[r][c])
			);
		end
	end

	// Output buffer control: filled at tile end, drained one row per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (fire && tile_end) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (take) begin
			cnt_q <= cnt_q + ROW_W'(1);
			if (cnt_q == ROW_W'(TILE - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Output rows: snapshot of the final sums, shifted up as rows leave
	always_ff @(posedge clk) begin
		if (fire && tile_end) begin
			rows_q <= acc_nxt;
		end else if (take) begin
			for (int i = 0; i < TILE - 1; i++) begin
				rows_q[i] <= rows_q[i+1];
			end
		end
	end

	assign res_valid     = busy_q;
	assign res.out_row   = cnt_q;
	assign res.c0        = OUT_W'(rows_q[0][0]);
	assign res.c1        = OUT_W'(rows_q[0][1]);
	assign res.c2        = OUT_W'(rows_q[0][2]);
	assign res.c3        = OUT_W'(rows_q[0][3]);
	assign res.tile_done = (cnt_q == ROW_W'(TILE - 1));

`ifndef SYNTHESIS
	// Input is held back only by a finished tile waiting on a full output buffer
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		op_stall |-> (tile_end && res_valid))
		else $error("input stalled without a pending tile end");

	// Rows of one tile leave in order
	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && !res.tile_done) |=>
		(res_valid && (res.out_row == ($past(res.out_row) + 2'd1))))
		else $error("tile rows out of order");

	// After the last row goes, the next row shown starts a new tile
	a_tile_start: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && res.tile_done) |=>
		(!res_valid || (res.out_row == 2'd0)))
		else $error("new tile does not start at row 0");
`endif

endmodule

`default_nettype wire

FILE: rtl/gtm_cell.sv
// One accumulator cell: registered saturated product and saturating accumulator.
`timescale 1ns / 1ps
`default_nettype none

module gtm_cell
	import gtm_pkg::*;
#(
	parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF,
	parameter int unsigned ACC_WIDTH     = ACC_WIDTH_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire gtm_ctl_t                 ctl,
	input  wire logic signed [OPERAND_WIDTH-1:0] a_op,
	input  wire logic signed [OPERAND_WIDTH-1:0] b_op,
	input  wire logic signed [ACC_WIDTH-1:0]     ld_val,
	output logic signed [ACC_WIDTH-1:0]          acc_nxt
);

	localparam int unsigned PROD_W = 2 * OPERAND_WIDTH;

	logic signed [PROD_W-1:0]    mul;
	logic signed [ACC_WIDTH-1:0] prod_sat;
	logic signed [ACC_WIDTH-1:0] prod_s2;
	logic signed [ACC_WIDTH-1:0] acc_q;
	logic signed [ACC_WIDTH:0]   sum;

	// Exact product, clamped to the accumulator range
	assign mul      = a_op * b_op;
	assign prod_sat = ACC_WIDTH'(gtm_sat(64'(mul), ACC_WIDTH));

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			prod_s2 <= prod_sat;
		end
	end

	// Saturating add: overflow when the two top bits of the sum differ
	assign sum = (ACC_WIDTH + 1)'(acc_q) + (ACC_WIDTH + 1)'(prod_s2);

	always_comb begin
		if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
			acc_nxt = sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
			                         : {1'b0, {(ACC_WIDTH-1){1'b1}}};
		end else begin
			acc_nxt = sum[ACC_WIDTH-1:0];
		end
	end

	// Accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.ld) begin
			acc_q <= ld_val;
		end else if (ctl.mac) begin
			acc_q <= ctl.clr ? '0 : acc_nxt;
		end
	end

endmodule

`default_nettype wire
